>>> hw/rtl/acn_pkg.sv
`timescale 1ns / 1ps
package acn_pkg;
	localparam int PIX_W  = 8;
	localparam int WGT_W  = 16;
	localparam int SUM_W  = 40;
	localparam int DIV_W  = 24;
	localparam int BIAS_W = 11;
	localparam int MASK_W = 4;
	localparam int NCH    = 4;
	localparam int FIFO_DEPTH = 2;

	localparam logic [DIV_W-1:0]  DIVISOR_RST = 24'd256;
	localparam logic [BIAS_W-1:0] BIAS_RST    = 11'd0;
	localparam logic [MASK_W-1:0] MASK_RST    = 4'hf;

	localparam logic [1:0] REG_DIVISOR = 2'd0;
	localparam logic [1:0] REG_BIAS    = 2'd1;
	localparam logic [1:0] REG_MASK    = 2'd2;

	localparam logic [1:0] CH_ALPHA = 2'd3;

	// one finished window, handed from accumulator to normalizer
	typedef struct packed {
		logic [NCH-1:0][SUM_W-1:0] sum;
		logic [SUM_W-1:0]          rdiv;
		logic [NCH-1:0][PIX_W-1:0] centre;
		logic                      masked;
	} win_t;

	typedef struct packed {
		logic [DIV_W-1:0]  divisor;
		logic [BIAS_W-1:0] bias;
		logic [MASK_W-1:0] target_mask;
	} cfg_t;
endpackage

>>> hw/rtl/acn_front.sv
`timescale 1ns / 1ps
module acn_front
	import acn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tap_valid,
	input  logic [PIX_W-1:0] pix_red,
	input  logic [PIX_W-1:0] pix_green,
	input  logic [PIX_W-1:0] pix_blue,
	input  logic [PIX_W-1:0] pix_alpha,
	input  logic [WGT_W-1:0] weight,
	input  logic             is_centre,
	input  logic             last_tap,
	input  logic             masked_out,
	input  logic [DIV_W-1:0] divisor,
	output logic             win_push,
	output win_t             win_data
);
	logic [NCH-1:0][SUM_W-1:0] sum_q, sum_n;
	logic [NCH-1:0][PIX_W-1:0] centre_q, centre_n;
	logic [NCH-1:0][PIX_W-1:0] pix;
	logic [SUM_W-1:0] rdiv_q, rdiv_base, rdiv_n;
	logic mid_q;

	assign pix = {pix_alpha, pix_blue, pix_green, pix_red};
	assign rdiv_base = mid_q ? rdiv_q : SUM_W'($signed(divisor));

	always_comb begin
		sum_n    = sum_q;
		centre_n = is_centre ? pix : centre_q;
		rdiv_n   = rdiv_base;
		if (pix_alpha == '0) begin
			rdiv_n = rdiv_base - SUM_W'($signed(weight));
		end else begin
			for (int c = 0; c < NCH; c++) begin
				sum_n[c] = sum_q[c] + SUM_W'($signed({1'b0, pix[c]}) * $signed(weight));
			end
		end
	end

	assign win_push        = tap_valid && last_tap;
	assign win_data.sum    = sum_n;
	assign win_data.rdiv   = rdiv_n;
	assign win_data.centre = centre_n;
	assign win_data.masked = masked_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			centre_q <= '0;
			rdiv_q   <= SUM_W'($signed(DIVISOR_RST));
			mid_q    <= 1'b0;
		end else if (tap_valid) begin
			rdiv_q <= rdiv_n;
			mid_q  <= !last_tap;
			if (last_tap) begin
				sum_q    <= '0;
				centre_q <= '0;
			end else begin
				sum_q    <= sum_n;
				centre_q <= centre_n;
			end
		end
	end
endmodule

>>> hw/rtl/acn_fifo.sv
`timescale 1ns / 1ps
module acn_fifo
	import acn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  win_t wdata,
	output logic full,
	input  logic pop,
	output win_t rdata,
	output logic empty
);
	win_t mem_q [FIFO_DEPTH];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = cnt_q == 2'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push && !full) wp_q <= !wp_q;
			if (pop && !empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

>>> hw/rtl/acn_back.sv
`timescale 1ns / 1ps
module acn_back
	import acn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             win_empty,
	input  win_t             win_in,
	output logic             win_pop,
	output logic             res_valid,
	input  logic             res_take,
	output logic [NCH-1:0][PIX_W-1:0] res_pix,
	output logic             res_write
);
	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHAN = 5'b00010,
		S_DIV  = 5'b00100,
		S_FIN  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t state_q;
	win_t   win_q;
	logic [1:0] ch_q;
	logic [NCH-1:0][PIX_W-1:0] res_q;
	logic wr_q, neg_q;
	logic [5:0] cnt_q;
	logic [SUM_W-1:0] num_q, den_q;
	logic [SUM_W:0] rem_q, trial;
	logic [SUM_W-1:0] sum_sel, den_sel, sum_abs, den_abs;
	logic need_div, qbit;
	logic [SUM_W+1:0] q_signed, q_biased;
	logic [PIX_W-1:0] q_clamped;

	assign sum_sel  = win_q.sum[ch_q];
	assign den_sel  = (ch_q == CH_ALPHA) ? SUM_W'($signed(cfg.divisor)) : win_q.rdiv;
	assign need_div = cfg.target_mask[ch_q] && (den_sel != '0);
	assign sum_abs  = sum_sel[SUM_W-1] ? -sum_sel : sum_sel;
	assign den_abs  = den_sel[SUM_W-1] ? -den_sel : den_sel;

	// restoring division on magnitudes, quotient shifts into num_q
	assign trial = {rem_q[SUM_W-1:0], num_q[SUM_W-1]};
	assign qbit  = trial >= {1'b0, den_q};

	always_comb begin
		q_signed = neg_q ? -{2'b00, num_q} : {2'b00, num_q};
		q_biased = q_signed + (SUM_W+2)'($signed(cfg.bias));
		if (q_biased[SUM_W+1])
			q_clamped = '0;
		else if (q_biased > (SUM_W+2)'(255))
			q_clamped = '1;
		else
			q_clamped = q_biased[PIX_W-1:0];
	end

	assign win_pop   = (state_q == S_IDLE) && !win_empty;
	assign res_valid = state_q == S_DONE;
	assign res_pix   = res_q;
	assign res_write = wr_q;

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (!win_empty) begin
					win_q <= win_in;
					ch_q  <= '0;
					wr_q  <= !win_in.masked;
					if (win_in.masked) res_q <= '0;
					else if (win_in.rdiv == '0) res_q <= win_in.centre;
				end
			end
			S_CHAN: begin
				num_q <= sum_abs;
				den_q <= den_abs;
				neg_q <= sum_sel[SUM_W-1] ^ den_sel[SUM_W-1];
				rem_q <= '0;
				cnt_q <= '0;
				if (!need_div) begin
					res_q[ch_q] <= win_q.centre[ch_q];
					ch_q <= ch_q + 2'd1;
				end
			end
			S_DIV: begin
				rem_q <= qbit ? trial - {1'b0, den_q} : trial;
				num_q <= {num_q[SUM_W-2:0], qbit};
				cnt_q <= cnt_q + 6'd1;
			end
			S_FIN: begin
				res_q[ch_q] <= q_clamped;
				ch_q <= ch_q + 2'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (!win_empty)
					state_q <= (win_in.masked || win_in.rdiv == '0) ? S_DONE : S_CHAN;
				S_CHAN: begin
					if (need_div) state_q <= S_DIV;
					else if (ch_q == CH_ALPHA) state_q <= S_DONE;
				end
				S_DIV:  if (cnt_q == 6'(SUM_W-1)) state_q <= S_FIN;
				S_FIN:  state_q <= (ch_q == CH_ALPHA) ? S_DONE : S_CHAN;
				S_DONE: if (res_take) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> cnt_q < 6'(SUM_W)) else $error("divider overran");
	a_masked_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !wr_q |-> res_q == '0) else $error("masked result not zero");
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_take |=> res_valid && $stable(res_q))
		else $error("result changed while waiting");
endmodule

>>> hw/rtl/alpha_aware_convolution_normalizer_top.sv
`timescale 1ns / 1ps
// rgba convolution normalizer: feed one window tap per transfer (pixel, weight,
// flags); taps are taken one per cycle while the window queue has room. on the
// last tap the window's sums go into a two-entry queue and a sequential
// normalizer divides each targeted channel with a one-bit-per-cycle divider:
// one channel at a time, shared by the whole window. masked and zero-divisor
// windows skip the divider.
// taps of the next windows keep streaming while the divider works, until the
// queue fills. results appear on a queue-style port (empty/pop). registers on
// the apb port: divisor at 0x0, bias at 0x4, target mask at 0x8.
module alpha_aware_convolution_normalizer_top
	import acn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// tap input
	input  logic        push,
	output logic        full,
	input  logic [7:0]  pix_red,
	input  logic [7:0]  pix_green,
	input  logic [7:0]  pix_blue,
	input  logic [7:0]  pix_alpha,
	input  logic [15:0] weight,
	input  logic        is_centre,
	input  logic        last_tap,
	input  logic        masked_out,
	// results
	output logic        empty,
	input  logic        pop,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic [7:0]  out_alpha,
	output logic        write_pixel
);
	cfg_t cfg_q;
	logic tap_xfer, win_push, win_full, win_pop, win_empty, res_valid;
	win_t win_wr, win_rd;
	logic [NCH-1:0][PIX_W-1:0] res_pix;

	// config registers, written in the apb access phase
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divisor     <= DIVISOR_RST;
			cfg_q.bias        <= BIAS_RST;
			cfg_q.target_mask <= MASK_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_DIVISOR: cfg_q.divisor     <= pwdata[DIV_W-1:0];
				REG_BIAS:    cfg_q.bias        <= pwdata[BIAS_W-1:0];
				REG_MASK:    cfg_q.target_mask <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_DIVISOR: prdata = 32'(cfg_q.divisor);
			REG_BIAS:    prdata = 32'(cfg_q.bias);
			REG_MASK:    prdata = 32'(cfg_q.target_mask);
			default:     prdata = '0;
		endcase
	end

	// taps stall only when the window queue is full
	assign full     = win_full;
	assign tap_xfer = push && !win_full;

	acn_front u_front (
		.clk, .arst_n,
		.tap_valid (tap_xfer),
		.pix_red, .pix_green, .pix_blue, .pix_alpha,
		.weight, .is_centre, .last_tap, .masked_out,
		.divisor   (cfg_q.divisor),
		.win_push  (win_push),
		.win_data  (win_wr)
	);

	acn_fifo u_fifo (
		.clk, .arst_n,
		.push  (win_push),
		.wdata (win_wr),
		.full  (win_full),
		.pop   (win_pop),
		.rdata (win_rd),
		.empty (win_empty)
	);

	acn_back u_back (
		.clk, .arst_n,
		.cfg       (cfg_q),
		.win_empty (win_empty),
		.win_in    (win_rd),
		.win_pop   (win_pop),
		.res_valid (res_valid),
		.res_take  (pop),
		.res_pix   (res_pix),
		.res_write (write_pixel)
	);

	assign empty     = !res_valid;
	assign out_red   = res_pix[0];
	assign out_green = res_pix[1];
	assign out_blue  = res_pix[2];
	assign out_alpha = res_pix[3];
endmodule
